### rtl/pvp_pkg.sv
// Package for the perspective vertex projection unit.
// Holds the word types, datapath widths and register indexes. No dependencies.
`default_nettype none
package pvp_pkg;
  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int MAG_W = 2 * CW + 2;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_X_SCALE  = 3'd0,
    REG_Y_SCALE  = 3'd1,
    REG_Z_SCALE  = 3'd2,
    REG_Z_OFFSET = 3'd3,
    REG_CAM_DIST = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 w_was_zero;
    logic                 saturated;
  } out_word_t;

  typedef struct packed {
    logic [CW:0]   rem;
    logic [CW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [CW:0]      div;
    lane_t [2:0]      lane;
    logic [2:0]       neg;
    logic [2:0]       ovf;
    logic             wzero;
  } cell_word_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
    mag_of = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction
endpackage
`default_nettype wire

### rtl/pvp_cell.sv
// One restoring-divide cell: produces one quotient bit for each of three lanes.
// Depends on pvp_pkg.
`default_nettype none
module pvp_cell
  import pvp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       in_valid,
  input  wire cell_word_t in_word,
  output logic            out_valid_r,
  output cell_word_t      out_word_r
);
  cell_word_t word_nxt;
  logic [CW+1:0] trial [3];
  logic [CW+1:0] diff  [3];

  always_comb begin
    word_nxt = in_word;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {in_word.lane[i].rem, in_word.lane[i].quo[CW-1]};
      diff[i]  = trial[i] - {1'b0, in_word.div};
      if (!diff[i][CW+1]) begin
        word_nxt.lane[i].rem = diff[i][CW:0];
      end else begin
        word_nxt.lane[i].rem = trial[i][CW:0];
      end
      word_nxt.lane[i].quo = {in_word.lane[i].quo[CW-2:0], ~diff[i][CW+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
    if (en) begin
      out_word_r <= word_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/perspective_vertex_project_unit.sv
// Perspective vertex projection: offset z, sparse matrix multiply, divide by w.
// A vertex passes the front stages, the 32-cell divider chain (one quotient bit
// per cell) and the output register; one vertex per cycle unless stalled.
// The whole pipeline advances unless the output register is full and stalled.
// Synchronous active-low reset clears valids and restores default registers.
// Depends on pvp_pkg and pvp_cell.
`default_nettype none
module perspective_vertex_project_unit
  import pvp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_word,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [CW-1:0]    cfg_wdata
);
  localparam logic [CW-1:0] ONE_Q = CW'(1) << FB;

  logic signed [CW-1:0] x_scale_r, y_scale_r, z_scale_r, z_offset_r, cam_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r  <= ONE_Q;
      y_scale_r  <= ONE_Q;
      z_scale_r  <= ONE_Q;
      z_offset_r <= '0;
      cam_dist_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_X_SCALE:  x_scale_r  <= cfg_wdata;
        REG_Y_SCALE:  y_scale_r  <= cfg_wdata;
        REG_Z_SCALE:  z_scale_r  <= cfg_wdata;
        REG_Z_OFFSET: z_offset_r <= cfg_wdata;
        REG_CAM_DIST: cam_dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  out_word_t out_word_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: shift z
  logic v1_r;
  logic signed [CW-1:0] x1_r, y1_r;
  logic signed [CW:0]   zs1_r;
  // stage 2: products
  logic v2_r;
  logic signed [2*CW-1:0] px2_r, py2_r;
  logic signed [2*CW:0]   pz2_r;
  logic signed [CW:0]     zs2_r;
  // stage 3: magnitudes
  logic v3_r;
  logic [MAG_W-1:0] mag3_r [3];
  logic [2:0]       sn3_r;
  logic [CW:0]      dmag3_r;
  logic             wn3_r, wz3_r;
  // stage 4: divider init
  logic       v4_r;
  cell_word_t c4_r;

  logic signed [MAG_W-1:0] nz;
  logic [MAG_W-1:0]        msh [3];
  logic [CW:0]             dsel;
  cell_word_t              c4_nxt;

  always_comb begin
    nz = MAG_W'(pz2_r) + (MAG_W'(z_offset_r) <<< FB);
    dsel = wz3_r ? (CW+1)'(1) : dmag3_r;
    c4_nxt.div   = dsel;
    c4_nxt.wzero = wz3_r;
    for (int i = 0; i < 3; i++) begin
      msh[i] = wz3_r ? (mag3_r[i] >> FB) : mag3_r[i];
      c4_nxt.neg[i] = wz3_r ? sn3_r[i] : (sn3_r[i] ^ wn3_r);
      c4_nxt.ovf[i] = msh[i][MAG_W-1:CW] >= (MAG_W-CW)'(dsel);
      c4_nxt.lane[i].rem = msh[i][2*CW:CW];
      c4_nxt.lane[i].quo = msh[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    if (adv) begin
      x1_r  <= in_word.in_x;
      y1_r  <= in_word.in_y;
      zs1_r <= (CW+1)'(in_word.in_z) + (CW+1)'(cam_dist_r);
      px2_r <= x1_r * x_scale_r;
      py2_r <= y1_r * y_scale_r;
      pz2_r <= zs1_r * z_scale_r;
      zs2_r <= zs1_r;
      mag3_r[0] <= mag_of(MAG_W'(px2_r));
      mag3_r[1] <= mag_of(MAG_W'(py2_r));
      mag3_r[2] <= mag_of(nz);
      sn3_r     <= {nz[MAG_W-1], py2_r[2*CW-1], px2_r[2*CW-1]};
      dmag3_r   <= zs2_r[CW] ? (CW+1)'(-zs2_r) : (CW+1)'(zs2_r);
      wn3_r     <= zs2_r[CW];
      wz3_r     <= zs2_r == '0;
      c4_r      <= c4_nxt;
    end
  end

  logic       cv [CW+1];
  cell_word_t cw [CW+1];
  assign cv[0] = v4_r;
  assign cw[0] = c4_r;

  for (genvar g = 0; g < CW; g++) begin : g_cell
    pvp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (adv),
      .in_valid    (cv[g]),
      .in_word     (cw[g]),
      .out_valid_r (cv[g+1]),
      .out_word_r  (cw[g+1])
    );
  end

  // sign, clamp
  logic [CW-1:0] lim  [3];
  logic [CW-1:0] res  [3];
  logic [2:0]    sat;
  cell_word_t    fin;
  out_word_t     out_nxt;

  always_comb begin
    fin = cw[CW];
    for (int i = 0; i < 3; i++) begin
      lim[i] = fin.neg[i] ? (CW'(1) << (CW-1)) : ((CW'(1) << (CW-1)) - CW'(1));
      sat[i] = fin.ovf[i] || (fin.lane[i].quo > lim[i]);
      if (sat[i]) begin
        res[i] = fin.neg[i] ? -lim[i] : lim[i];
      end else begin
        res[i] = fin.neg[i] ? -fin.lane[i].quo : fin.lane[i].quo;
      end
    end
    out_nxt.out_x      = res[0];
    out_nxt.out_y      = res[1];
    out_nxt.out_z      = res[2];
    out_nxt.w_was_zero = fin.wzero;
    out_nxt.saturated  = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv[CW];
    end
    if (adv) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule
`default_nettype wire
